// ----- rtl/i2cbe_pkg.sv -----
`timescale 1ns / 1ps

package i2cbe_pkg;

  // buffer geometry
  localparam int BUFFER_DEPTH = 16;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  localparam logic [CNT_W-1:0] DEPTH_CNT       = CNT_W'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] NEARLY_FULL_CNT = CNT_W'(BUFFER_DEPTH - 1);

  // field widths fixed by the interface
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 5;

  localparam logic [BYTE_W-1:0] STATUS_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] PAD_BYTE    = 8'hFF;

  // bus status codes, low three bits masked
  localparam logic [BYTE_W-1:0] ST_SLA_W_ACK    = 8'h60;
  localparam logic [BYTE_W-1:0] ST_DATA_RX_ACK  = 8'h80;
  localparam logic [BYTE_W-1:0] ST_DATA_RX_NACK = 8'h88;
  localparam logic [BYTE_W-1:0] ST_STOP_RESTART = 8'hA0;
  localparam logic [BYTE_W-1:0] ST_SLA_R_ACK    = 8'hA8;
  localparam logic [BYTE_W-1:0] ST_DATA_TX_ACK  = 8'hB8;
  localparam logic [BYTE_W-1:0] ST_DATA_TX_NACK = 8'hC0;
  localparam logic [BYTE_W-1:0] ST_LAST_TX_ACK  = 8'hC8;

  typedef enum logic [1:0] {
    REQ_HOST_WR = 2'd0,
    REQ_HOST_RD = 2'd1,
    REQ_STATUS  = 2'd2,
    REQ_SERVED  = 2'd3
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_RX_NOTIFY  = 1'b0,
    CFG_REQ_NOTIFY = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_next;
    logic              bus_reset;
    logic [BYTE_W-1:0] host_byte;
    logic [LEN_W-1:0]  bytes_available;
    logic              receive_done;
    logic [LEN_W-1:0]  received_length;
    logic              request_raised;
  } out_item_t;

endpackage

// ----- rtl/i2cbe_in_if.sv -----
`timescale 1ns / 1ps

interface i2cbe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] status_code;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output status_code, output data_byte,
                  input ready);
  modport sink (input valid, input req_type, input status_code, input data_byte,
                output ready);
endinterface

// ----- rtl/i2cbe_out_if.sv -----
`timescale 1ns / 1ps

interface i2cbe_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       ack_next;
  logic       bus_reset;
  logic [7:0] host_byte;
  logic [4:0] bytes_available;
  logic       receive_done;
  logic [4:0] received_length;
  logic       request_raised;

  modport source (output valid, output tx_valid, output tx_byte, output ack_next,
                  output bus_reset, output host_byte, output bytes_available,
                  output receive_done, output received_length, output request_raised,
                  input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input ack_next,
                input bus_reset, input host_byte, input bytes_available,
                input receive_done, input received_length, input request_raised,
                output ready);
endinterface

// ----- rtl/i2c_slave_buffer_engine_core.sv -----
`timescale 1ns / 1ps

// Data buffer side of an I2C slave. Each input item is a host byte write, a host byte read,
// a bus status event or a request-served notice, and each gives exactly one result item.
// Bytes live in a 16-entry single-read synchronous buffer memory; fill count, read position
// and the pending-request flag are registers updated when the item is taken. An item's result
// is registered in the read stage, where the buffer read completes, and then in the output
// register before it is presented on the output, and the block takes one item per cycle as
// long as results are taken. Bus writes store bytes and answer NACK once only one free entry
// remains; NACK or STOP reports the received length when receive notification is on. A read
// address clears the buffer and either sends a 0xFF pad byte at once, the buffer being empty,
// or, with request notification on, raises a request and sends on the next request-served
// item. An exhausted buffer pads with 0xFF. Unknown status codes answer bus_reset and leave
// the buffer alone. Configuration must be written through a plain write port only while the
// block is idle; the block itself does not enforce this.
module i2c_slave_buffer_engine_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  i2cbe_pkg::cfg_idx_e cfg_idx_i,
  input  logic                cfg_data_i,
  i2cbe_in_if.sink            in_i,
  i2cbe_out_if.source         out_o
);
  import i2cbe_pkg::*;

  // configuration
  logic rx_notify_q, req_notify_q;

  // buffer bookkeeping
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             pend_q, pend_d;

  // buffer memory, registered read
  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we, mem_re;

  // read stage: result built at acceptance, waiting for the buffer data
  logic      rd_valid_q;
  out_item_t rd_res_q, res_d;
  logic      rd_tx_mem_q, rd_host_mem_q;
  logic      tx_mem_d, host_mem_d;

  // output register
  logic      out_valid_q;
  out_item_t out_res_q, out_res_d;

  logic             in_acc, rd_adv, have_data;
  logic [BYTE_W-1:0] status;
  logic [CNT_W-1:0] rd_idx_inc;

  // handshake: read stage drains into the output register when that is free or taken
  assign rd_adv    = rd_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !rd_valid_q || rd_adv;
  assign in_acc    = in_i.valid && in_i.ready;

  assign status     = in_i.status_code & STATUS_MASK;
  assign have_data  = rd_idx_q < fill_q;
  assign rd_idx_inc = rd_idx_q + CNT_W'(1);

  // decode one item against the current bookkeeping
  always_comb begin
    fill_d     = fill_q;
    rd_idx_d   = rd_idx_q;
    pend_d     = pend_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    tx_mem_d   = 1'b0;
    host_mem_d = 1'b0;
    res_d      = '0;

    case (req_type_e'(in_i.req_type))
      REQ_HOST_WR: begin
        if (fill_q < DEPTH_CNT) begin
          mem_we = 1'b1;
          fill_d = fill_q + CNT_W'(1);
        end
      end
      REQ_HOST_RD: begin
        if (have_data) begin
          mem_re     = 1'b1;
          host_mem_d = 1'b1;
          rd_idx_d   = rd_idx_inc;
        end
      end
      REQ_SERVED: begin
        if (pend_q) begin
          pend_d         = 1'b0;
          res_d.tx_valid = 1'b1;
          if (have_data) begin
            mem_re         = 1'b1;
            tx_mem_d       = 1'b1;
            rd_idx_d       = rd_idx_inc;
            res_d.ack_next = rd_idx_inc < fill_q;
          end else begin
            res_d.tx_byte = PAD_BYTE;
          end
        end
      end
      default: begin
        // status event; any pending request is dropped as the bus moved on
        pend_d = 1'b0;
        case (status)
          ST_SLA_W_ACK: begin
            fill_d         = '0;
            rd_idx_d       = '0;
            res_d.ack_next = 1'b1;
          end
          ST_DATA_RX_ACK, ST_DATA_RX_NACK: begin
            if (fill_q < DEPTH_CNT) begin
              mem_we = 1'b1;
              fill_d = fill_q + CNT_W'(1);
            end
            if (status == ST_DATA_RX_ACK) begin
              res_d.ack_next = fill_d < NEARLY_FULL_CNT;
            end else begin
              res_d.ack_next = 1'b1;
              if (rx_notify_q && (fill_d != '0)) begin
                res_d.receive_done    = 1'b1;
                res_d.received_length = LEN_W'(fill_d);
              end
            end
          end
          ST_STOP_RESTART: begin
            res_d.ack_next = 1'b1;
            if (rx_notify_q && (fill_q != '0)) begin
              res_d.receive_done    = 1'b1;
              res_d.received_length = LEN_W'(fill_q);
            end
          end
          ST_SLA_R_ACK: begin
            fill_d   = '0;
            rd_idx_d = '0;
            if (req_notify_q) begin
              pend_d               = 1'b1;
              res_d.request_raised = 1'b1;
            end else begin
              // buffer just cleared, so only padding goes out
              res_d.tx_valid = 1'b1;
              res_d.tx_byte  = PAD_BYTE;
            end
          end
          ST_DATA_TX_ACK: begin
            res_d.tx_valid = 1'b1;
            if (have_data) begin
              mem_re         = 1'b1;
              tx_mem_d       = 1'b1;
              rd_idx_d       = rd_idx_inc;
              res_d.ack_next = rd_idx_inc < fill_q;
            end else begin
              res_d.tx_byte = PAD_BYTE;
            end
          end
          ST_DATA_TX_NACK, ST_LAST_TX_ACK: begin
            res_d.ack_next = 1'b1;
          end
          default: begin
            res_d.bus_reset = 1'b1;
            res_d.ack_next  = 1'b1;
          end
        endcase
      end
    endcase

    res_d.bytes_available = (rd_idx_d < fill_d) ? LEN_W'(fill_d - rd_idx_d) : '0;
  end

  // memory port: write at the fill position, read at the read position
  always_ff @(posedge clk_i) begin
    if (in_acc && mem_we) begin
      mem[fill_q[ADDR_W-1:0]] <= in_i.data_byte;
    end
    if (in_acc && mem_re) begin
      rdata_q <= mem[rd_idx_q[ADDR_W-1:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_notify_q  <= 1'b0;
      req_notify_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RX_NOTIFY:  rx_notify_q  <= cfg_data_i;
        CFG_REQ_NOTIFY: req_notify_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bookkeeping and read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      rd_idx_q   <= '0;
      pend_q     <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        fill_q   <= fill_d;
        rd_idx_q <= rd_idx_d;
        pend_q   <= pend_d;
      end
      if (in_acc) begin
        rd_valid_q <= 1'b1;
      end else if (rd_adv) begin
        rd_valid_q <= 1'b0;
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_res_q      <= res_d;
      rd_tx_mem_q   <= tx_mem_d;
      rd_host_mem_q <= host_mem_d;
    end
  end

  // merge buffer data into the result
  always_comb begin
    out_res_d = rd_res_q;
    if (rd_tx_mem_q) begin
      out_res_d.tx_byte = rdata_q;
    end
    if (rd_host_mem_q) begin
      out_res_d.host_byte = rdata_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_adv) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.tx_valid        = out_res_q.tx_valid;
  assign out_o.tx_byte         = out_res_q.tx_byte;
  assign out_o.ack_next        = out_res_q.ack_next;
  assign out_o.bus_reset       = out_res_q.bus_reset;
  assign out_o.host_byte       = out_res_q.host_byte;
  assign out_o.bytes_available = out_res_q.bytes_available;
  assign out_o.receive_done    = out_res_q.receive_done;
  assign out_o.received_length = out_res_q.received_length;
  assign out_o.request_raised  = out_res_q.request_raised;

  // read position never passes the fill level, which never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_idx_q <= fill_q) && (fill_q <= DEPTH_CNT))
    else $error("buffer bookkeeping out of range");

  // buffer read data must hold while the read stage is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && (rd_tx_mem_q || rd_host_mem_q) && !rd_adv) |=>
      (rd_valid_q && $stable(rdata_q)))
    else $error("buffer read data lost during stall");

  // a buffer byte is routed to at most one result field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> !(rd_tx_mem_q && rd_host_mem_q))
    else $error("buffer byte routed twice");

  // a forced stop never carries a transmit byte or a reception report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.bus_reset) |-> !(out_res_q.tx_valid || out_res_q.receive_done))
    else $error("bus reset result carries other events");

endmodule
